/* hdl/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared constants and the result record passed from the parser to the
// output register of the top level.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // Opcode that ends the connection once its message completes.
  localparam logic [3:0] OpClose = 4'h8;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  // One result item as produced by the parser.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] msg_opcode;
    logic       frame_last;
    logic       message_last;
    logic       close_seen;
  } wsdf_result_t;

endpackage

/* hdl/wsdf_parser.sv */
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Holds the header, length, mask and message state and turns one received
// byte per step into at most one result item.
// ----------------------------------------------------------------------------
module wsdf_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output wsdf_pkg::wsdf_result_t res_o
);

  // Parse phase codes.
  localparam logic [2:0] PhHdr0 = 3'd0;
  localparam logic [2:0] PhHdr1 = 3'd1;
  localparam logic [2:0] PhExt  = 3'd2;
  localparam logic [2:0] PhKey  = 3'd3;
  localparam logic [2:0] PhData = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  frame_op_q, frame_op_d;
  logic        masked_q, masked_d;
  logic [63:0] remaining_q, remaining_d;
  logic [2:0]  ext_cnt_q, ext_cnt_d;
  logic [31:0] key_word_q, key_word_d;
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic [3:0]  remembered_op_q, remembered_op_d;
  logic        frag_pending_q, frag_pending_d;
  logic        closed_q, closed_d;

  logic        emit_valid;
  logic        emit_has;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic [3:0]  eff_op;
  logic        msg_last;
  logic        close_hit;
  logic [63:0] ext_len;
  logic [7:0]  key_byte;
  logic [1:0]  key_idx_next;

  // The opcode in effect comes from the remembered opcode inside a fragmented
  // message, and from the frame itself otherwise.
  assign eff_op = (!fin_q || frag_pending_q) ? remembered_op_q : frame_op_q;

  assign ext_len      = {remaining_q[55:0], byte_i};
  assign key_idx_next = mask_idx_q + 2'd1;

  // Select the key byte for the current payload position, first byte on top.
  always_comb begin
    unique case (mask_idx_q)
      2'd0:    key_byte = key_word_q[31:24];
      2'd1:    key_byte = key_word_q[23:16];
      2'd2:    key_byte = key_word_q[15:8];
      default: key_byte = key_word_q[7:0];
    endcase
  end

  // Next state and result for one byte.
  always_comb begin
    phase_d         = phase_q;
    fin_d           = fin_q;
    frame_op_d      = frame_op_q;
    masked_d        = masked_q;
    remaining_d     = remaining_q;
    ext_cnt_d       = ext_cnt_q;
    key_word_d      = key_word_q;
    mask_idx_d      = mask_idx_q;
    remembered_op_d = remembered_op_q;
    frag_pending_d  = frag_pending_q;
    closed_d        = closed_q;
    emit_valid      = 1'b0;
    emit_has        = 1'b0;
    emit_byte       = 8'd0;
    emit_last       = 1'b0;

    if (step_i && !closed_q) begin
      unique case (phase_q)
        PhHdr1: begin
          masked_d    = byte_i[7];
          remaining_d = 64'd0;
          if (byte_i[6:0] == wsdf_pkg::LenCode16) begin
            ext_cnt_d = 3'd1;
            phase_d   = PhExt;
          end else if (byte_i[6:0] == wsdf_pkg::LenCode64) begin
            ext_cnt_d = 3'd7;
            phase_d   = PhExt;
          end else begin
            remaining_d = {57'd0, byte_i[6:0]};
            mask_idx_d  = 2'd0;
            if (byte_i[7]) begin
              phase_d = PhKey;
            end else if (byte_i[6:0] == 7'd0) begin
              emit_valid = 1'b1;
              emit_last  = 1'b1;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhExt: begin
          remaining_d = ext_len;
          if (ext_cnt_q == 3'd0) begin
            mask_idx_d = 2'd0;
            if (masked_q) begin
              phase_d = PhKey;
            end else if (ext_len == 64'd0) begin
              emit_valid = 1'b1;
              emit_last  = 1'b1;
            end else begin
              phase_d = PhData;
            end
          end else begin
            ext_cnt_d = ext_cnt_q - 3'd1;
          end
        end
        PhKey: begin
          key_word_d = {key_word_q[23:0], byte_i};
          mask_idx_d = key_idx_next;
          if (key_idx_next == 2'd0) begin
            if (remaining_q == 64'd0) begin
              emit_valid = 1'b1;
              emit_last  = 1'b1;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          mask_idx_d  = key_idx_next;
          remaining_d = remaining_q - 64'd1;
          emit_valid  = 1'b1;
          emit_has    = 1'b1;
          emit_byte   = masked_q ? (byte_i ^ key_byte) : byte_i;
          emit_last   = (remaining_q == 64'd1);
        end
        default: begin
          // First header byte; unused phase codes land here as well.
          fin_d      = byte_i[7];
          frame_op_d = byte_i[3:0];
          if (!byte_i[7] && (byte_i[3:0] != 4'd0)) begin
            remembered_op_d = byte_i[3:0];
          end
          ext_cnt_d  = 3'd0;
          mask_idx_d = 2'd0;
          phase_d    = PhHdr1;
        end
      endcase

      // Message bookkeeping on every emitted result.
      if (emit_valid) begin
        if (emit_has && !fin_q) begin
          frag_pending_d = 1'b1;
        end
        if (emit_last && fin_q) begin
          frag_pending_d = 1'b0;
        end
        if (emit_last && fin_q && (eff_op == wsdf_pkg::OpClose)) begin
          closed_d = 1'b1;
        end
        if (emit_last) begin
          phase_d = PhHdr0;
        end
      end
    end
  end

  assign msg_last  = emit_last && fin_q;
  assign close_hit = msg_last && (eff_op == wsdf_pkg::OpClose);

  // Result record.
  assign res_valid_o         = emit_valid;
  assign res_o.payload_byte  = emit_byte;
  assign res_o.has_byte      = emit_has;
  assign res_o.msg_opcode    = eff_op;
  assign res_o.frame_last    = emit_last;
  assign res_o.message_last  = msg_last;
  assign res_o.close_seen    = close_hit;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhHdr0;
      fin_q           <= 1'b0;
      frame_op_q      <= 4'd0;
      masked_q        <= 1'b0;
      remaining_q     <= 64'd0;
      ext_cnt_q       <= 3'd0;
      key_word_q      <= 32'd0;
      mask_idx_q      <= 2'd0;
      remembered_op_q <= 4'd0;
      frag_pending_q  <= 1'b0;
      closed_q        <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      fin_q           <= fin_d;
      frame_op_q      <= frame_op_d;
      masked_q        <= masked_d;
      remaining_q     <= remaining_d;
      ext_cnt_q       <= ext_cnt_d;
      key_word_q      <= key_word_d;
      mask_idx_q      <= mask_idx_d;
      remembered_op_q <= remembered_op_d;
      frag_pending_q  <= frag_pending_d;
      closed_q        <= closed_d;
    end
  end

endmodule

/* hdl/websocket_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer, top level
// Accepts a byte per cycle unless the output stalls; streams unmasked payload.
// ----------------------------------------------------------------------------
// The block accepts one byte item per clock cycle while the result register can
// move on, and gives at most one result item per byte: a payload byte, or a
// marker for an empty frame. A byte is held in the input register and parsed
// into the result register, from which its result is presented; header, length
// and key bytes give no result. The per-byte path is set by the 64-bit length
// counter, which is decremented and compared once per payload byte. After a
// close message ends, bytes are still accepted but give no result until reset.
module websocket_frame_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       has_byte_o,
  output logic [3:0] msg_opcode_o,
  output logic       frame_last_o,
  output logic       message_last_o,
  output logic       close_seen_o
);

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   out_valid_q;
  wsdf_pkg::wsdf_result_t out_q;
  logic                   advance;
  logic                   res_valid;
  wsdf_pkg::wsdf_result_t res;

  // The held item moves on when the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  wsdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_q.payload_byte;
  assign has_byte_o     = out_q.has_byte;
  assign msg_opcode_o   = out_q.msg_opcode;
  assign frame_last_o   = out_q.frame_last;
  assign message_last_o = out_q.message_last;
  assign close_seen_o   = out_q.close_seen;

endmodule

/* hdl/wsdf_checker.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer checker
// Watches the top-level ports for result items that break the framing rules.
// ----------------------------------------------------------------------------
module wsdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_o,
  input logic       has_byte_o,
  input logic [3:0] msg_opcode_o,
  input logic       frame_last_o,
  input logic       message_last_o,
  input logic       close_seen_o
);

  // An empty-frame marker carries a zero byte.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> (payload_byte_o == 8'd0))
    else $error("empty-frame marker carries a nonzero byte");

  // An empty-frame marker always ends its frame.
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> frame_last_o)
    else $error("empty-frame marker does not end the frame");

  // A message can only end on the last item of a frame.
  a_msg_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && message_last_o) |-> frame_last_o)
    else $error("message end without frame end");

  // Close is only flagged at the end of a close message.
  a_close_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && close_seen_o) |->
      (message_last_o && (msg_opcode_o == wsdf_pkg::OpClose)))
    else $error("close flagged outside a close message end");

  // Once the close item is taken, nothing follows it.
  a_close_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && close_seen_o) |=> !out_valid_o)
    else $error("item delivered after close");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .payload_byte_o (payload_byte_o),
  .has_byte_o     (has_byte_o),
  .msg_opcode_o   (msg_opcode_o),
  .frame_last_o   (frame_last_o),
  .message_last_o (message_last_o),
  .close_seen_o   (close_seen_o)
);

/* test/websocket_frame_deframer_checker.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer checker
// Watches both channels of the deframer. Every accepted byte goes through a
// local frame parser that predicts the result items; every accepted result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        has_byte_i,
  input  logic [3:0]  msg_opcode_i,
  input  logic        frame_last_i,
  input  logic        message_last_i,
  input  logic        close_seen_i,
  output int unsigned pending_results_o,
  output int unsigned mismatches_o
);

  typedef enum logic [2:0] {
    PhHeader0,
    PhHeader1,
    PhExtLen,
    PhMaskKey,
    PhPayload
  } parse_phase_e;

  // Parser state as the block should hold it.
  parse_phase_e phase;
  logic         fin_q;
  logic [3:0]   frame_op;
  logic         masked_q;
  logic [63:0]  bytes_left;
  logic [2:0]   ext_left;
  logic [31:0]  key_word;
  logic [1:0]   key_pos;
  logic [3:0]   held_op;
  logic         frag_open;
  logic         stream_closed;

  // Failures seen so far.
  int unsigned  fail_count = 0;

  // Results predicted but not yet seen on the output channel.
  wsdf_pkg::wsdf_result_t unmasked_results_q[$];
  wsdf_pkg::wsdf_result_t want_item;
  wsdf_pkg::wsdf_result_t got_item;

  assign mismatches_o = fail_count;

  // Queues one result and advances the message state on a frame end.
  task automatic push_result(input logic has, input logic [7:0] value, input logic last);
    wsdf_pkg::wsdf_result_t r;
    logic msg_end;
    r.msg_opcode   = (!fin_q || frag_open) ? held_op : frame_op;
    msg_end        = last && fin_q;
    r.payload_byte = has ? value : 8'h00;
    r.has_byte     = has;
    r.frame_last   = last;
    r.message_last = msg_end;
    r.close_seen   = msg_end && (r.msg_opcode == wsdf_pkg::OpClose);
    unmasked_results_q.push_back(r);
    if (has && !fin_q) frag_open = 1'b1;
    if (msg_end) frag_open = 1'b0;
    if (r.close_seen) stream_closed = 1'b1;
    if (last) phase = PhHeader0;
  endtask

  // The length is complete: go to the key, the payload, or close an empty frame.
  task automatic finish_length();
    key_pos = '0;
    if (masked_q) begin
      phase = PhMaskKey;
    end else if (bytes_left == '0) begin
      push_result(1'b0, 8'h00, 1'b1);
    end else begin
      phase = PhPayload;
    end
  endtask

  // Runs one received byte through the parser.
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] value;
    if (stream_closed) return;
    case (phase)
      PhHeader1: begin
        masked_q   = b[7];
        bytes_left = '0;
        if (b[6:0] == wsdf_pkg::LenCode16) begin
          ext_left = 3'd1;
          phase    = PhExtLen;
        end else if (b[6:0] == wsdf_pkg::LenCode64) begin
          ext_left = 3'd7;
          phase    = PhExtLen;
        end else begin
          bytes_left = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PhExtLen: begin
        bytes_left = {bytes_left[55:0], b};
        if (ext_left == '0) begin
          finish_length();
        end else begin
          ext_left = ext_left - 3'd1;
        end
      end
      PhMaskKey: begin
        key_word = {key_word[23:0], b};
        key_pos  = key_pos + 2'd1;
        if (key_pos == '0) begin
          if (bytes_left == '0) begin
            push_result(1'b0, 8'h00, 1'b1);
          end else begin
            phase = PhPayload;
          end
        end
      end
      PhPayload: begin
        value = masked_q ? (b ^ key_word[(3 - key_pos) * 8 +: 8]) : b;
        key_pos    = key_pos + 2'd1;
        bytes_left = bytes_left - 64'd1;
        push_result(1'b1, value, bytes_left == '0);
      end
      default: begin
        // First header byte; unused phase codes land here as well.
        fin_q    = b[7];
        frame_op = b[3:0];
        if (!fin_q && |frame_op) held_op = frame_op;
        ext_left = '0;
        key_pos  = '0;
        phase    = PhHeader1;
      end
    endcase
  endtask

  // Counts a failure and reports the first few in detail.
  task automatic note_mismatch(input string what, input wsdf_pkg::wsdf_result_t want,
                               input wsdf_pkg::wsdf_result_t got);
    fail_count = fail_count + 1;
    if (fail_count <= 10) begin
      $display("%s: expected byte=%02h has=%0b op=%0h fl=%0b ml=%0b cls=%0b",
               what, want.payload_byte, want.has_byte, want.msg_opcode,
               want.frame_last, want.message_last, want.close_seen);
      $display("%s: actual   byte=%02h has=%0b op=%0h fl=%0b ml=%0b cls=%0b",
               what, got.payload_byte, got.has_byte, got.msg_opcode,
               got.frame_last, got.message_last, got.close_seen);
    end
  endtask

  // Compare accepted results first, then predict from the accepted byte.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase         = PhHeader0;
      fin_q         = 1'b0;
      frame_op      = '0;
      masked_q      = 1'b0;
      bytes_left    = '0;
      ext_left      = '0;
      key_word      = '0;
      key_pos       = '0;
      held_op       = '0;
      frag_open     = 1'b0;
      stream_closed = 1'b0;
      unmasked_results_q.delete();
      pending_results_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_item = {payload_byte_i, has_byte_i, msg_opcode_i, frame_last_i,
                    message_last_i, close_seen_i};
        if (unmasked_results_q.size() == 0) begin
          note_mismatch("unexpected result", '0, got_item);
        end else begin
          want_item = unmasked_results_q.pop_front();
          if (got_item !== want_item) note_mismatch("result mismatch", want_item, got_item);
        end
      end
      if (in_valid_i && in_ready_i) deframe_byte(data_byte_i);
      pending_results_o <= unmasked_results_q.size();
    end
  end

endmodule

/* test/websocket_frame_deframer_top_tb.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds directed and random frame streams into the deframer under varying
// idle patterns on both channels, ends with a close message followed by
// bytes that must be dropped, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top_tb;

  // Opcodes used by the stimulus.
  localparam logic [3:0] OpCont         = 4'h0;
  localparam logic [3:0] OpText         = 4'h1;
  localparam logic [3:0] OpBinary       = 4'h2;
  localparam logic [3:0] OpReservedData = 4'h7;
  localparam logic [3:0] OpPing         = 4'h9;
  localparam logic [3:0] OpPong         = 4'hA;
  localparam logic [3:0] OpReservedCtl  = 4'hF;

  localparam int RandomBytes = 1200;

  // How the payload length is encoded in the header.
  typedef enum int {
    LenShort,
    LenExt16,
    LenExt64
  } len_form_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic        has_byte;
  logic [3:0]  msg_opcode;
  logic        frame_last;
  logic        message_last;
  logic        close_seen;
  int unsigned pending_results;
  int unsigned mismatches;

  int send_idle_pct = 32;
  int recv_idle_pct = 49;
  int bytes_sent = 0;
  int random_start;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  websocket_frame_deframer_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .payload_byte_o (payload_byte),
    .has_byte_o     (has_byte),
    .msg_opcode_o   (msg_opcode),
    .frame_last_o   (frame_last),
    .message_last_o (message_last),
    .close_seen_o   (close_seen)
  );

  websocket_frame_deframer_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .data_byte_i       (data_byte),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .payload_byte_i    (payload_byte),
    .has_byte_i        (has_byte),
    .msg_opcode_i      (msg_opcode),
    .frame_last_i      (frame_last),
    .message_last_i    (message_last),
    .close_seen_i      (close_seen),
    .pending_results_o (pending_results),
    .mismatches_o      (mismatches)
  );

  // The receiver stalls at random according to the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one byte, after an optional random gap, and waits until it is taken.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends a complete frame: header, extended length, key and random payload.
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opcode,
                            input logic masked, input len_form_e form,
                            input logic [63:0] length, input logic [31:0] key);
    logic [6:0] code;
    code = (form == LenExt16) ? wsdf_pkg::LenCode16 :
           (form == LenExt64) ? wsdf_pkg::LenCode64 : length[6:0];
    send_byte({fin, rsv, opcode});
    send_byte({masked, code});
    if (form == LenExt16) begin
      for (int n = 1; n >= 0; n--) send_byte(length[8 * n +: 8]);
    end
    if (form == LenExt64) begin
      for (int n = 7; n >= 0; n--) send_byte(length[8 * n +: 8]);
    end
    if (masked) begin
      for (int n = 3; n >= 0; n--) send_byte(key[8 * n +: 8]);
    end
    for (longint unsigned i = 0; i < length; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Any opcode but close, weighted toward the data opcodes.
  function automatic logic [3:0] random_opcode();
    logic [3:0] op;
    if ($urandom_range(99) < 60) begin
      op = $urandom_range(1) ? OpText : OpBinary;
    end else begin
      op = 4'($urandom_range(15));
      if (op == wsdf_pkg::OpClose) op = OpReservedCtl;
    end
    return op;
  endfunction

  // A frame with random reserved bits, masking, length encoding and size.
  task automatic send_random_frame(input logic fin, input logic [3:0] opcode);
    logic [2:0] rsv;
    int pick;
    rsv  = ($urandom_range(99) < 20) ? 3'($urandom_range(7)) : 3'd0;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_frame(fin, rsv, opcode, $urandom_range(99) < 80, LenShort,
                 64'($urandom_range(8)), $urandom);
    end else if (pick < 80) begin
      send_frame(fin, rsv, opcode, $urandom_range(99) < 80, LenShort,
                 64'($urandom_range(40, 9)), $urandom);
    end else if (pick < 88) begin
      send_frame(fin, rsv, opcode, $urandom_range(99) < 80, LenShort,
                 64'($urandom_range(125, 41)), $urandom);
    end else if (pick < 95) begin
      send_frame(fin, rsv, opcode, $urandom_range(99) < 80, LenExt16,
                 64'($urandom_range(300)), $urandom);
    end else begin
      send_frame(fin, rsv, opcode, $urandom_range(99) < 80, LenExt64,
                 64'($urandom_range(40)), $urandom);
    end
  endtask

  // A message: optional fragments with control frames between them, then a
  // final frame. Some messages are replaced by a lone frame of random kind.
  task automatic send_random_message();
    int frags;
    logic [3:0] op;
    op = random_opcode();
    if ($urandom_range(99) < 15) begin
      send_random_frame(1'($urandom_range(1)), op);
      return;
    end
    frags = ($urandom_range(99) < 40) ? $urandom_range(3, 1) : 0;
    for (int k = 0; k < frags; k++) begin
      send_random_frame(1'b0, (k == 0) ? op : OpCont);
      if ($urandom_range(99) < 20) send_random_frame(1'b1, $urandom_range(1) ? OpPing : OpPong);
    end
    send_random_frame(1'b1, (frags != 0) ? OpCont : op);
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Continuation with nothing remembered, then its final frame.
    send_frame(1'b0, 3'd0, OpCont, 1'b0, LenShort, 64'd2, 32'h0);
    send_frame(1'b1, 3'd0, OpCont, 1'b1, LenShort, 64'd1, 32'h0000_0000);
    // Empty frames, unmasked and masked.
    send_frame(1'b1, 3'd0, OpPing, 1'b0, LenShort, 64'd0, 32'h0);
    send_frame(1'b1, 3'd0, OpPong, 1'b1, LenShort, 64'd0, 32'hFFFF_FFFF);
    // Fragmented text with a control frame and an empty fragment in between.
    send_frame(1'b0, 3'd0, OpText, 1'b1, LenShort, 64'd3, 32'hA5C3_0FF0);
    send_frame(1'b1, 3'd0, OpPing, 1'b1, LenShort, 64'd2, 32'h1234_5678);
    send_frame(1'b0, 3'd0, OpCont, 1'b0, LenShort, 64'd0, 32'h0);
    send_frame(1'b1, 3'd0, OpCont, 1'b1, LenShort, 64'd5, 32'hFFFF_FFFF);
    // Reserved bits and unknown opcodes; the longest short length.
    send_frame(1'b0, 3'd7, OpReservedCtl, 1'b0, LenShort, 64'd0, 32'h0);
    send_frame(1'b1, 3'd5, OpReservedData, 1'b1, LenShort, 64'd125, $urandom);
    // Extended lengths, including zero and non-minimal encodings.
    send_frame(1'b1, 3'd0, OpBinary, 1'b0, LenExt16, 64'd0, 32'h0);
    send_frame(1'b1, 3'd0, OpBinary, 1'b1, LenExt16, 64'd130, $urandom);
    send_frame(1'b1, 3'd0, OpText, 1'b0, LenExt64, 64'd3, 32'h0);
    send_frame(1'b1, 3'd0, OpText, 1'b1, LenExt64, 64'd0, $urandom);

    // Random messages under three idle patterns.
    random_start = bytes_sent;
    while (bytes_sent < random_start + RandomBytes) begin
      if (send_idle_pct == 32 && bytes_sent >= random_start + RandomBytes / 3) begin
        // Let the block drain completely before swapping the idle rates.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        send_idle_pct = 49;
        recv_idle_pct = 32;
      end else if (send_idle_pct == 49 &&
                   bytes_sent >= random_start + 2 * RandomBytes / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_message();
    end

    // Clear any open fragment, then close the connection.
    send_frame(1'b1, 3'd0, OpText, 1'b0, LenShort, 64'd0, 32'h0);
    if ($urandom_range(1)) begin
      send_frame(1'b1, 3'($urandom_range(7)), wsdf_pkg::OpClose, 1'($urandom_range(1)),
                 LenShort, 64'($urandom_range(3)), $urandom);
    end else begin
      send_frame(1'b0, 3'd0, wsdf_pkg::OpClose, 1'b1, LenShort, 64'd2, $urandom);
      send_frame(1'b1, 3'd0, OpCont, 1'b0, LenShort, 64'd1, 32'h0);
    end
    // Bytes after the close must give no result.
    repeat (6) send_byte(8'($urandom_range(255)));
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_200_000;
    $display("status: fail");
    $finish;
  end

endmodule
